// File: src/gnpe_pkg.sv
// ----------------------------------------------------------------------------
// gnpe_pkg: shared definitions for the Gabor noise point evaluator
// Constants, register indices, control structs and the ROM contents.
// ----------------------------------------------------------------------------
package gnpe_pkg;

  localparam int MaxImpulses  = 64;
  localparam int CountW       = $clog2(MaxImpulses + 1);
  localparam int ExpTableBits = 10;
  localparam int CosTableBits = 10;
  localparam int ExpN         = 1 << ExpTableBits;
  localparam int CosN         = 1 << CosTableBits;
  localparam int ExpShift     = 19 - ExpTableBits;
  localparam int CfgIndexW    = 8;

  localparam logic [31:0] GenMult   = 32'd3039177861;
  localparam logic [31:0] InvTwoPi  = 32'd683565276;
  localparam longint unsigned TwoPiQ28 = 64'd1686629713;

  // Register indices on the configuration channel.
  localparam logic [CfgIndexW-1:0] CfgInverseRadius    = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgKernelRadius     = 8'd1;
  localparam logic [CfgIndexW-1:0] CfgPoissonThreshold = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgAmplitude        = 8'd3;
  localparam logic [CfgIndexW-1:0] CfgGaussRate        = 8'd4;
  localparam logic [CfgIndexW-1:0] CfgCarrierX         = 8'd5;
  localparam logic [CfgIndexW-1:0] CfgCarrierY         = 8'd6;
  localparam logic [CfgIndexW-1:0] CfgSeedOffset       = 8'd7;

  typedef struct packed {
    logic        [23:0] inverse_radius;
    logic        [15:0] kernel_radius;
    logic        [31:0] poisson_threshold;
    logic        [15:0] amplitude;
    logic        [23:0] gauss_rate;
    logic signed [15:0] carrier_x;
    logic signed [15:0] carrier_y;
    logic        [31:0] seed_offset;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic done;
  } status_t;

  typedef struct packed {
    logic signed [31:0] noise_value;
    logic               count_capped;
  } result_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SX, S_SY, S_RAD, S_KX, S_KY, S_KYR, S_CELL, S_T0, S_T0R,
    S_CNT, S_CNTD, S_CNTT, S_UX, S_UXR, S_UYR, S_UWR, S_UAR, S_DX2, S_DY2,
    S_D2, S_R2M, S_ARG, S_EI, S_PHX, S_PHY, S_TURN, S_COS, S_AC, S_G, S_W,
    S_ACC, S_DONE
  } state_t;

  typedef logic        [16:0] exp_table_t [ExpN];
  typedef logic signed [15:0] cos_table_t [CosN];

  // Unsigned division by shift and subtract, used while the tables are built.
  function automatic longint unsigned div_small(input longint unsigned num,
                                                input int unsigned     den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= 64'(den)) begin
        rem    = rem - 64'(den);
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-x) over [0,8) in Q.16, built as repeated products of one ratio.
  function automatic exp_table_t build_exp_table();
    exp_table_t        tab;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   e;
    longint unsigned   ratio;
    longint            sum;
    x    = 64'd1 << (35 - ExpTableBits);
    term = 64'd1 << 32;
    sum  = 64'sd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 16; n++) begin
      term = div_small((term * x) >> 32, n);
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    ratio = longint'(sum);
    for (int k = 0; k < ExpN; k++) begin
      tab[k] = 17'((e + 64'd32768) >> 16);
      e = (e * ratio) >> 32;
    end
    return tab;
  endfunction

  // cos over one turn in Q.14, from a Taylor series on the first quarter.
  function automatic cos_table_t build_cos_table();
    cos_table_t      tab;
    longint unsigned a;
    longint unsigned t;
    longint          c;
    longint          s;
    longint          v;
    longint          mag;
    int              quarter;
    int              r;
    for (int k = 0; k < CosN; k++) begin
      quarter = k >> (CosTableBits - 2);
      r       = k & ((CosN >> 2) - 1);
      a = (TwoPiQ28 * longint'(r)) >> CosTableBits;
      t = 64'd1 << 28;
      c = 64'sd1 << 28;
      s = 0;
      for (int n = 1; n <= 24; n++) begin
        t = div_small((t * a) >> 28, n);
        case (n & 3)
          1: s = s + longint'(t);
          2: c = c - longint'(t);
          3: s = s - longint'(t);
          default: c = c + longint'(t);
        endcase
      end
      if (c < 0) c = 0;
      if (s < 0) s = 0;
      case (quarter)
        0: v = c;
        1: v = -s;
        2: v = -c;
        default: v = s;
      endcase
      mag = ((v < 0 ? -v : v) + 8192) >>> 14;
      tab[k] = 16'(v < 0 ? -mag : mag);
    end
    return tab;
  endfunction

  localparam exp_table_t ExpTable = build_exp_table();
  localparam cos_table_t CosTable = build_cos_table();

endpackage

// File: src/gnpe_mul.sv
// ----------------------------------------------------------------------------
// gnpe_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module gnpe_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: src/gnpe_rom.sv
// ----------------------------------------------------------------------------
// gnpe_rom: exponential and cosine lookup tables
// Two constant tables with registered read data.
// ----------------------------------------------------------------------------
module gnpe_rom (
  input  logic                                 clk,
  input  logic        [gnpe_pkg::ExpTableBits-1:0] exp_addr,
  input  logic        [gnpe_pkg::CosTableBits-1:0] cos_addr,
  output logic        [16:0]                   exp_data,
  output logic signed [15:0]                   cos_data
);

  always_ff @(posedge clk) begin
    exp_data <= gnpe_pkg::ExpTable[exp_addr];
    cos_data <= gnpe_pkg::CosTable[cos_addr];
  end

endmodule

// File: src/gnpe_core.sv
// ----------------------------------------------------------------------------
// gnpe_core: sequencer and datapath of the noise evaluator
// Walks the nine cells and their impulses, issuing every product to the
// shared multiplier one step at a time.
// ----------------------------------------------------------------------------
module gnpe_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [23:0]        x_in,
  input  logic signed [23:0]        y_in,
  input  gnpe_pkg::cfg_t            cfg,
  input  logic                      out_free,
  output gnpe_pkg::status_t         status,
  output gnpe_pkg::result_t         result
);

  localparam int CW = gnpe_pkg::CountW;

  gnpe_pkg::state_t state, state_next;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p;
  logic        [16:0] exp_data;
  logic signed [15:0] cos_data;

  logic signed [23:0] x_pos, y_pos;
  logic        [15:0] cx, cy, fx, fy;
  logic        [31:0] rad2;
  logic signed [31:0] kxr, kyr;
  logic        [1:0]  di_cnt, dj_cnt;
  logic        [31:0] gen, t;
  logic        [CW-1:0] count, left;
  logic               capped;
  logic signed [17:0] lx, ly, dx, dy;
  logic        [16:0] uw;
  logic        [34:0] d2a;
  logic        [31:0] d2;
  logic               ev_ok;
  logic        [16:0] ev;
  logic signed [50:0] ph_acc;
  logic signed [30:0] ph16;
  logic signed [33:0] acc;

  logic        [15:0] ca, cb;
  logic        [31:0] seed_sum, seed;
  logic signed [17:0] lx_cell, ly_cell;
  logic        [35:0] d2_sum;
  logic signed [50:0] phase;
  logic signed [17:0] w;
  logic               last_cell, more_imp, count_go;

  function automatic logic [31:0] interleave(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] z;
    for (int i = 0; i < 16; i++) begin
      z[2*i]     = a[i];
      z[2*i + 1] = b[i];
    end
    return z;
  endfunction

  gnpe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  gnpe_rom u_rom (
    .clk      (clk),
    .exp_addr (p[24 + gnpe_pkg::ExpShift +: gnpe_pkg::ExpTableBits]),
    .cos_addr (p[48 - gnpe_pkg::CosTableBits +: gnpe_pkg::CosTableBits]),
    .exp_data (exp_data),
    .cos_data (cos_data)
  );

  assign ca       = cx + 16'(di_cnt) - 16'd1;
  assign cb       = cy + 16'(dj_cnt) - 16'd1;
  assign seed_sum = interleave(ca, cb) + cfg.seed_offset;
  assign seed     = (seed_sum == 32'd0) ? 32'd1 : seed_sum;
  assign lx_cell  = 18'(19'({3'b000, fx}) + 19'h10000 - {1'b0, di_cnt, 16'h0000});
  assign ly_cell  = 18'(19'({3'b000, fy}) + 19'h10000 - {1'b0, dj_cnt, 16'h0000});
  assign d2_sum   = {1'b0, d2a} + {1'b0, p[34:0]};
  assign phase    = ph_acc + p[50:0];
  assign w        = $signed({1'b0, uw}) - 18'sd65536;
  assign last_cell = (di_cnt == 2'd2) && (dj_cnt == 2'd2);
  assign more_imp  = (left > CW'(1));
  assign count_go  = (t > cfg.poisson_threshold) && (count < CW'(gnpe_pkg::MaxImpulses));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnpe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    status.ready = 1'b0;
    status.done  = 1'b0;
    case (state)
      gnpe_pkg::S_IDLE: begin
        status.ready = 1'b1;
        if (start) state_next = gnpe_pkg::S_SX;
      end
      gnpe_pkg::S_SX: begin
        mul_a = 33'(x_pos);
        mul_b = {9'b0, cfg.inverse_radius};
        state_next = gnpe_pkg::S_SY;
      end
      gnpe_pkg::S_SY: begin
        mul_a = 33'(y_pos);
        mul_b = {9'b0, cfg.inverse_radius};
        state_next = gnpe_pkg::S_RAD;
      end
      gnpe_pkg::S_RAD: begin
        mul_a = {17'b0, cfg.kernel_radius};
        mul_b = {17'b0, cfg.kernel_radius};
        state_next = gnpe_pkg::S_KX;
      end
      gnpe_pkg::S_KX: begin
        mul_a = 33'(cfg.carrier_x);
        mul_b = {17'b0, cfg.kernel_radius};
        state_next = gnpe_pkg::S_KY;
      end
      gnpe_pkg::S_KY: begin
        mul_a = 33'(cfg.carrier_y);
        mul_b = {17'b0, cfg.kernel_radius};
        state_next = gnpe_pkg::S_KYR;
      end
      gnpe_pkg::S_KYR: state_next = gnpe_pkg::S_CELL;
      gnpe_pkg::S_CELL: state_next = gnpe_pkg::S_T0;
      gnpe_pkg::S_T0: begin
        mul_a = {1'b0, gen};
        mul_b = {1'b0, gnpe_pkg::GenMult};
        state_next = gnpe_pkg::S_T0R;
      end
      gnpe_pkg::S_T0R: state_next = gnpe_pkg::S_CNT;
      gnpe_pkg::S_CNT: begin
        if (count_go) begin
          mul_a = {1'b0, gen};
          mul_b = {1'b0, gnpe_pkg::GenMult};
          state_next = gnpe_pkg::S_CNTD;
        end else if (count != '0) begin
          state_next = gnpe_pkg::S_UX;
        end else if (last_cell) begin
          state_next = gnpe_pkg::S_DONE;
        end else begin
          state_next = gnpe_pkg::S_CELL;
        end
      end
      gnpe_pkg::S_CNTD: begin
        mul_a = {1'b0, t};
        mul_b = {1'b0, p[31:0]};
        state_next = gnpe_pkg::S_CNTT;
      end
      gnpe_pkg::S_CNTT: state_next = gnpe_pkg::S_CNT;
      gnpe_pkg::S_UX: begin
        mul_a = {1'b0, gen};
        mul_b = {1'b0, gnpe_pkg::GenMult};
        state_next = gnpe_pkg::S_UXR;
      end
      gnpe_pkg::S_UXR: begin
        mul_a = {1'b0, p[31:0]};
        mul_b = {1'b0, gnpe_pkg::GenMult};
        state_next = gnpe_pkg::S_UYR;
      end
      gnpe_pkg::S_UYR: begin
        mul_a = {1'b0, p[31:0]};
        mul_b = {1'b0, gnpe_pkg::GenMult};
        state_next = gnpe_pkg::S_UWR;
      end
      gnpe_pkg::S_UWR: begin
        mul_a = {1'b0, p[31:0]};
        mul_b = {1'b0, gnpe_pkg::GenMult};
        state_next = gnpe_pkg::S_UAR;
      end
      gnpe_pkg::S_UAR: state_next = gnpe_pkg::S_DX2;
      gnpe_pkg::S_DX2: begin
        mul_a = 33'(dx);
        mul_b = 33'(dx);
        state_next = gnpe_pkg::S_DY2;
      end
      gnpe_pkg::S_DY2: begin
        mul_a = 33'(dy);
        mul_b = 33'(dy);
        state_next = gnpe_pkg::S_D2;
      end
      gnpe_pkg::S_D2: begin
        if (d2_sum[35:32] == 4'd0) state_next = gnpe_pkg::S_R2M;
        else if (more_imp) state_next = gnpe_pkg::S_UX;
        else if (last_cell) state_next = gnpe_pkg::S_DONE;
        else state_next = gnpe_pkg::S_CELL;
      end
      gnpe_pkg::S_R2M: begin
        mul_a = {1'b0, d2};
        mul_b = {1'b0, rad2};
        state_next = gnpe_pkg::S_ARG;
      end
      gnpe_pkg::S_ARG: begin
        mul_a = {1'b0, p[63:32]};
        mul_b = {9'b0, cfg.gauss_rate};
        state_next = gnpe_pkg::S_EI;
      end
      gnpe_pkg::S_EI: begin
        mul_a = 33'(kxr);
        mul_b = 33'(dx);
        state_next = gnpe_pkg::S_PHX;
      end
      gnpe_pkg::S_PHX: begin
        mul_a = 33'(kyr);
        mul_b = 33'(dy);
        state_next = gnpe_pkg::S_PHY;
      end
      gnpe_pkg::S_PHY: state_next = gnpe_pkg::S_TURN;
      gnpe_pkg::S_TURN: begin
        mul_a = 33'(ph16);
        mul_b = {1'b0, gnpe_pkg::InvTwoPi};
        state_next = gnpe_pkg::S_COS;
      end
      gnpe_pkg::S_COS: state_next = gnpe_pkg::S_AC;
      gnpe_pkg::S_AC: begin
        mul_a = {17'b0, cfg.amplitude};
        mul_b = 33'(cos_data);
        state_next = gnpe_pkg::S_G;
      end
      gnpe_pkg::S_G: begin
        mul_a = 33'($signed(p[31:0]));
        mul_b = {16'b0, ev};
        state_next = gnpe_pkg::S_W;
      end
      gnpe_pkg::S_W: begin
        mul_a = 33'(w);
        mul_b = 33'($signed(p[49:26]));
        state_next = gnpe_pkg::S_ACC;
      end
      gnpe_pkg::S_ACC: begin
        if (more_imp) state_next = gnpe_pkg::S_UX;
        else if (last_cell) state_next = gnpe_pkg::S_DONE;
        else state_next = gnpe_pkg::S_CELL;
      end
      gnpe_pkg::S_DONE: begin
        status.done = out_free;
        if (out_free) state_next = gnpe_pkg::S_IDLE;
      end
      default: state_next = gnpe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      gnpe_pkg::S_IDLE: begin
        x_pos <= x_in;
        y_pos <= y_in;
      end
      gnpe_pkg::S_SY: begin
        cx <= p[47:32];
        fx <= p[31:16];
      end
      gnpe_pkg::S_RAD: begin
        cy <= p[47:32];
        fy <= p[31:16];
      end
      gnpe_pkg::S_KX: rad2 <= p[31:0];
      gnpe_pkg::S_KY: kxr  <= $signed(p[31:0]);
      gnpe_pkg::S_KYR: begin
        kyr    <= $signed(p[31:0]);
        di_cnt <= 2'd0;
        dj_cnt <= 2'd0;
        acc    <= '0;
        capped <= 1'b0;
      end
      gnpe_pkg::S_CELL: begin
        gen   <= seed;
        lx    <= lx_cell;
        ly    <= ly_cell;
        count <= '0;
      end
      gnpe_pkg::S_T0R: begin
        gen <= p[31:0];
        t   <= p[31:0];
      end
      gnpe_pkg::S_CNT: begin
        if (count_go) begin
          count <= count + CW'(1);
        end else begin
          left <= count;
          if (count == CW'(gnpe_pkg::MaxImpulses)) capped <= 1'b1;
        end
      end
      gnpe_pkg::S_CNTD: gen <= p[31:0];
      gnpe_pkg::S_CNTT: t <= p[63:32];
      gnpe_pkg::S_UXR: begin
        gen <= p[31:0];
        dx  <= lx - $signed({2'b00, p[31:16]});
      end
      gnpe_pkg::S_UYR: begin
        gen <= p[31:0];
        dy  <= ly - $signed({2'b00, p[31:16]});
      end
      gnpe_pkg::S_UWR: begin
        gen <= p[31:0];
        uw  <= p[31:15];
      end
      gnpe_pkg::S_UAR: gen <= p[31:0];
      gnpe_pkg::S_DY2: d2a <= p[34:0];
      gnpe_pkg::S_D2: begin
        d2 <= d2_sum[31:0];
        if (d2_sum[35:32] != 4'd0) left <= left - CW'(1);
      end
      gnpe_pkg::S_EI: ev_ok <= (p[55:43] == 13'd0);
      gnpe_pkg::S_PHX: begin
        ev     <= ev_ok ? exp_data : 17'd0;
        ph_acc <= p[50:0];
      end
      gnpe_pkg::S_PHY: ph16 <= 31'(phase >>> 20);
      gnpe_pkg::S_ACC: begin
        acc  <= acc + 34'($signed(p[39:16]));
        left <= left - CW'(1);
      end
      default: ;
    endcase
    // Step to the next cell once the current one has no impulses left.
    if ((state == gnpe_pkg::S_CNT && !count_go && count == '0) ||
        (state == gnpe_pkg::S_D2 && d2_sum[35:32] != 4'd0 && !more_imp) ||
        (state == gnpe_pkg::S_ACC && !more_imp)) begin
      if (dj_cnt == 2'd2) begin
        dj_cnt <= 2'd0;
        di_cnt <= di_cnt + 2'd1;
      end else begin
        dj_cnt <= dj_cnt + 2'd1;
      end
    end
  end

  always_comb begin
    if (acc[33:31] == 3'b000 || acc[33:31] == 3'b111) result.noise_value = acc[31:0];
    else if (acc[33]) result.noise_value = 32'sh80000000;
    else result.noise_value = 32'sh7fffffff;
    result.count_capped = capped;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state == gnpe_pkg::S_CNT) |-> (count <= CW'(gnpe_pkg::MaxImpulses)))
    else $error("impulse count passed the cap");

  a_cap_flag: assert property (@(posedge clk) disable iff (rst)
    (state == gnpe_pkg::S_CNT && count == CW'(gnpe_pkg::MaxImpulses)) |=> capped)
    else $error("capped flag not set at the impulse cap");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && status.ready) |=> !status.ready)
    else $error("core still ready after taking a point");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == gnpe_pkg::S_CELL) |-> (di_cnt != 2'd3 && dj_cnt != 2'd3))
    else $error("cell counter out of range");

endmodule

// File: src/gabor_noise_point_evaluator_unit.sv
// ----------------------------------------------------------------------------
// gabor_noise_point_evaluator_unit: sparse Gabor noise at one point
// Configuration registers, stream handshakes and the result register
// around the sequenced evaluation core.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata: x_pos[23:0], y_pos[47:24]
//  m_axis    out        tdata: noise_value[31:0]; tuser: count_capped[0]
//  cfg       in         cfg_index selects the register, cfg_data the value
//
// Every product passes one at a time through the single shared multiplier
// under the core sequencer. Reset (rst, synchronous) returns the
// configuration registers to their reset values and the core to idle,
// and empties the result register; the tables are constant.
// The result word waits in its own register, so the core takes the next
// point while that word is stalled; it holds its second result until the
// register is free. Configuration words are always taken.
// ----------------------------------------------------------------------------
module gabor_noise_point_evaluator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // x_pos[23:0], y_pos[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // noise_value[31:0]
  output logic [0:0]  m_axis_tuser,   // count_capped[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gnpe_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  gnpe_pkg::cfg_t    cfg;
  gnpe_pkg::status_t status;
  gnpe_pkg::result_t result;
  logic              out_free;

  // The register file accepts a word every cycle; unknown indices are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_radius    <= 24'd223150;
      cfg.kernel_radius     <= 16'd4812;
      cfg.poisson_threshold <= 32'd6;
      cfg.amplitude         <= 16'd4096;
      cfg.gauss_rate        <= 24'd131759;
      cfg.carrier_x         <= 16'sd1138;
      cfg.carrier_y         <= 16'sd1138;
      cfg.seed_offset       <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gnpe_pkg::CfgInverseRadius:    cfg.inverse_radius    <= cfg_data[23:0];
        gnpe_pkg::CfgKernelRadius:     cfg.kernel_radius     <= cfg_data[15:0];
        gnpe_pkg::CfgPoissonThreshold: cfg.poisson_threshold <= cfg_data;
        gnpe_pkg::CfgAmplitude:        cfg.amplitude         <= cfg_data[15:0];
        gnpe_pkg::CfgGaussRate:        cfg.gauss_rate        <= cfg_data[23:0];
        gnpe_pkg::CfgCarrierX:         cfg.carrier_x         <= $signed(cfg_data[15:0]);
        gnpe_pkg::CfgCarrierY:         cfg.carrier_y         <= $signed(cfg_data[15:0]);
        gnpe_pkg::CfgSeedOffset:       cfg.seed_offset       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = status.ready;

  gnpe_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (s_axis_tvalid),
    .x_in     ($signed(s_axis_tdata[23:0])),
    .y_in     ($signed(s_axis_tdata[47:24])),
    .cfg      (cfg),
    .out_free (out_free),
    .status   (status),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (status.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      m_axis_tdata    <= result.noise_value;
      m_axis_tuser[0] <= result.count_capped;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    status.done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while still held");

endmodule

// File: tb/gnpe_checker.sv
// ----------------------------------------------------------------------------
// gnpe_checker: result predictor and scoreboard for the noise evaluator
// Watches the configuration, point and result channels, predicts every
// result from its own copy of the registers and tables, and counts errors.
// ----------------------------------------------------------------------------
module gnpe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [gnpe_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          outstanding
);

  localparam gnpe_pkg::cfg_t ResetSettings = '{
    inverse_radius: 24'd223150, kernel_radius: 16'd4812, poisson_threshold: 32'd6,
    amplitude: 16'd4096, gauss_rate: 24'd131759, carrier_x: 16'sd1138,
    carrier_y: 16'sd1138, seed_offset: 32'd0
  };

  gnpe_pkg::cfg_t    settings = ResetSettings;
  gnpe_pkg::result_t expected_noise [$];
  longint  exp_rom [gnpe_pkg::ExpN];
  longint  cos_rom [gnpe_pkg::CosN];

  initial begin
    fill_tables();
  end

  task automatic fill_tables();
    longint unsigned x, term, e, ratio, a, t;
    longint          sum, c, s, v, mag;
    int              quarter, r;
    x    = 64'd1 << (35 - gnpe_pkg::ExpTableBits);
    term = 64'd1 << 32;
    sum  = 64'sd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 32) / n;
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    ratio = sum;
    for (int k = 0; k < gnpe_pkg::ExpN; k++) begin
      exp_rom[k] = longint'((e + 64'd32768) >> 16);
      e = (e * ratio) >> 32;
    end
    for (int k = 0; k < gnpe_pkg::CosN; k++) begin
      quarter = k >> (gnpe_pkg::CosTableBits - 2);
      r       = k % (gnpe_pkg::CosN / 4);
      a = (64'd1686629713 * r) >> gnpe_pkg::CosTableBits;
      t = 64'd1 << 28;
      c = 64'sd1 << 28;
      s = 0;
      for (int n = 1; n <= 24; n++) begin
        t = ((t * a) >> 28) / n;
        case (n % 4)
          1: s += longint'(t);
          2: c -= longint'(t);
          3: s -= longint'(t);
          default: c += longint'(t);
        endcase
      end
      if (c < 0) c = 0;
      if (s < 0) s = 0;
      case (quarter)
        0: v = c;
        1: v = -s;
        2: v = -c;
        default: v = s;
      endcase
      mag = ((v < 0 ? -v : v) + 8192) >>> 14;
      cos_rom[k] = (v < 0) ? -mag : mag;
    end
  endtask

  function automatic logic [31:0] morton(logic [15:0] a, logic [15:0] b);
    logic [31:0] z;
    for (int i = 0; i < 16; i++) begin
      z[2*i]   = a[i];
      z[2*i+1] = b[i];
    end
    return z;
  endfunction

  function automatic gnpe_pkg::result_t predict_noise(logic [23:0] xp, logic [23:0] yp);
    gnpe_pkg::result_t res;
    longint          sx, sy, cxi, cyi, fx, fy, kx, ky, lx, ly, acc;
    longint          dx, dy, d2, ev, env, phase, turns, g16, w;
    longint unsigned rad2, r2, arg, ei, ci;
    logic [31:0]     st, seed, t, ux, uy, uw;
    int              count;
    logic            capped;
    sx  = longint'($signed(xp)) * longint'(settings.inverse_radius);
    sy  = longint'($signed(yp)) * longint'(settings.inverse_radius);
    cxi = sx >>> 32;
    cyi = sy >>> 32;
    fx  = (sx >>> 16) & 64'hFFFF;
    fy  = (sy >>> 16) & 64'hFFFF;
    kx  = longint'(settings.carrier_x);
    ky  = longint'(settings.carrier_y);
    rad2 = longint'(settings.kernel_radius) * longint'(settings.kernel_radius);
    acc    = 0;
    capped = 1'b0;
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        seed = morton(16'(cxi + di), 16'(cyi + dj)) + settings.seed_offset;
        // A seed of zero would lock the generator at zero.
        if (seed == 32'd0) seed = 32'd1;
        lx = fx - longint'(di) * 65536;
        ly = fy - longint'(dj) * 65536;
        st = seed * gnpe_pkg::GenMult;
        t  = st;
        count = 0;
        while (t > settings.poisson_threshold && count < gnpe_pkg::MaxImpulses) begin
          count++;
          st = st * gnpe_pkg::GenMult;
          t  = 32'(({32'd0, t} * {32'd0, st}) >> 32);
        end
        if (count >= gnpe_pkg::MaxImpulses) capped = 1'b1;
        for (int m = 0; m < count; m++) begin
          st = st * gnpe_pkg::GenMult; ux = st;
          st = st * gnpe_pkg::GenMult; uy = st;
          st = st * gnpe_pkg::GenMult; uw = st;
          st = st * gnpe_pkg::GenMult;   // angle draw, not used
          dx = lx - longint'(ux[31:16]);
          dy = ly - longint'(uy[31:16]);
          d2 = dx * dx + dy * dy;
          if (d2 < (64'sd1 << 32)) begin
            r2  = (longint'(d2) * rad2) >> 32;
            arg = (r2 * settings.gauss_rate) >> 24;
            ei  = arg >> gnpe_pkg::ExpShift;
            ev  = (ei < gnpe_pkg::ExpN) ? exp_rom[ei] : 0;
            env = longint'(settings.amplitude) * ev;
            phase = kx * (dx * longint'(settings.kernel_radius))
                  + ky * (dy * longint'(settings.kernel_radius));
            turns = (phase >>> 20) * longint'(gnpe_pkg::InvTwoPi);
            ci  = (longint'(turns) >> (48 - gnpe_pkg::CosTableBits))
                  & (gnpe_pkg::CosN - 1);
            g16 = (env * cos_rom[ci]) >>> 26;
            w   = longint'(uw >> 15) - 65536;
            acc += (w * g16) >>> 16;
          end
        end
      end
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    res.noise_value  = 32'(acc);
    res.count_capped = capped;
    return res;
  endfunction

  always @(posedge clk) begin
    gnpe_pkg::result_t want;
    int                errs;
    errs = 0;
    if (rst) begin
      expected_noise.delete();
      settings <= ResetSettings;
      failures <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gnpe_pkg::CfgInverseRadius:    settings.inverse_radius    <= cfg_data[23:0];
          gnpe_pkg::CfgKernelRadius:     settings.kernel_radius     <= cfg_data[15:0];
          gnpe_pkg::CfgPoissonThreshold: settings.poisson_threshold <= cfg_data;
          gnpe_pkg::CfgAmplitude:        settings.amplitude         <= cfg_data[15:0];
          gnpe_pkg::CfgGaussRate:        settings.gauss_rate        <= cfg_data[23:0];
          gnpe_pkg::CfgCarrierX:         settings.carrier_x         <= cfg_data[15:0];
          gnpe_pkg::CfgCarrierY:         settings.carrier_y         <= cfg_data[15:0];
          gnpe_pkg::CfgSeedOffset:       settings.seed_offset       <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_noise.push_back(predict_noise(s_axis_tdata[23:0], s_axis_tdata[47:24]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_noise.size() == 0) begin
          $error("unexpected result word: noise_value %0d", $signed(m_axis_tdata));
          errs++;
        end else begin
          want = expected_noise.pop_front();
          if (m_axis_tdata !== want.noise_value) begin
            $error("noise_value: expected %0d, actual %0d",
                   want.noise_value, $signed(m_axis_tdata));
            errs++;
          end
          if (m_axis_tuser[0] !== want.count_capped) begin
            $error("count_capped: expected %0b, actual %0b",
                   want.count_capped, m_axis_tuser[0]);
            errs++;
          end
        end
      end
      failures <= failures + errs;
    end
    outstanding <= expected_noise.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Gabor noise point evaluator
// Drives points and register settings with random idling on both sides,
// while the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;

  // The limit is set several times above a run made entirely of points
  // whose cells all reach the impulse cap.
  localparam int CycleLimit      = 30000000;
  localparam int FirstUnusedIndex = 8;
  localparam int DrainCycles     = 60;
  localparam int RandomPhases    = 5;
  localparam int PointsPerPhase  = 86;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [gnpe_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int   failures;
  int   outstanding;
  // When set, the sender or the receiver never idles.
  logic sender_calm   = 1'b0;
  logic receiver_calm = 1'b0;

  always #5 clk = ~clk;

  gabor_noise_point_evaluator_unit DUT (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gnpe_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures, .outstanding
  );

  // The receiver stalls at random, about thirty percent of the time, unless calm.
  always @(posedge clk)
    m_axis_tready <= receiver_calm || ($urandom_range(0, 99) >= 30);

  // Offers one point and holds it until the block takes the word. The
  // valid stays high into the next point unless the sender chooses a gap.
  task automatic send_point(logic [23:0] xp, logic [23:0] yp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yp, xp};
    do @(posedge clk); while (!s_axis_tready);
    if (!sender_calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Lowers the point valid and waits until every result has been seen,
  // then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [gnpe_pkg::CfgIndexW-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register, plus one write to an index past the last
  // register, which the block must ignore.
  task automatic apply_settings(gnpe_pkg::cfg_t c);
    write_reg(gnpe_pkg::CfgInverseRadius, 32'(c.inverse_radius));
    write_reg(gnpe_pkg::CfgKernelRadius, 32'(c.kernel_radius));
    write_reg(gnpe_pkg::CfgPoissonThreshold, c.poisson_threshold);
    write_reg(gnpe_pkg::CfgAmplitude, 32'(c.amplitude));
    write_reg(gnpe_pkg::CfgGaussRate, 32'(c.gauss_rate));
    write_reg(gnpe_pkg::CfgCarrierX, 32'($unsigned(c.carrier_x)));
    write_reg(gnpe_pkg::CfgCarrierY, 32'($unsigned(c.carrier_y)));
    write_reg(gnpe_pkg::CfgSeedOffset, c.seed_offset);
    write_reg(gnpe_pkg::CfgIndexW'($urandom_range(FirstUnusedIndex, 255)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random settings with a moderate impulse density, so that points stay
  // quick; the other registers range over their whole width.
  function automatic gnpe_pkg::cfg_t random_settings();
    gnpe_pkg::cfg_t c;
    c.inverse_radius    = 24'($urandom);
    c.kernel_radius     = 16'($urandom);
    c.poisson_threshold = $urandom_range(80000000, 1580000000);
    c.amplitude         = 16'($urandom);
    c.gauss_rate        = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 400000));
    c.carrier_x         = 16'($urandom);
    c.carrier_y         = 16'($urandom);
    c.seed_offset       = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    return c;
  endfunction

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    gnpe_pkg::cfg_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the origin, where the centre cell has a zero seed,
    // and the corners of the coordinate range.
    send_point(24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7FFFFF, 24'h800000);
    send_point(24'h800000, 24'h7FFFFF);
    send_point(24'hFFFFFF, 24'h000001);
    drain();

    // A threshold of zero ends the count only when the running product falls to zero or the cap is reached.
    c = random_settings();
    c.poisson_threshold = 32'd0;
    c.gauss_rate        = 24'd131759;
    apply_settings(c);
    send_point(24'h000100, 24'h000200);
    send_point(24'($urandom), 24'($urandom));
    drain();

    // A full-scale threshold leaves every cell empty.
    c.poisson_threshold = 32'hFFFFFFFF;
    apply_settings(c);
    send_point(24'h123456, 24'hABCDEF);
    send_point(24'h000000, 24'h000000);
    drain();

    // Register extremes with dense impulses and large amplitude, aiming
    // at a saturated sum.
    c = '{inverse_radius: 24'hFFFFFF, kernel_radius: 16'hFFFF,
          poisson_threshold: 32'd1, amplitude: 16'hFFFF, gauss_rate: 24'd0,
          carrier_x: 16'sh8000, carrier_y: 16'sh7FFF, seed_offset: 32'hFFFFFFFF};
    apply_settings(c);
    send_point(24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h800000);
    send_point(24'h000010, 24'hFFFFF0);
    drain();

    // Exp argument beyond the table, zero inverse radius and zero carrier.
    c = '{inverse_radius: 24'd0, kernel_radius: 16'h8000,
          poisson_threshold: 32'd200000000, amplitude: 16'd0,
          gauss_rate: 24'hFFFFFF, carrier_x: 16'sh7FFF, carrier_y: 16'sh8000,
          seed_offset: 32'd0};
    apply_settings(c);
    send_point(24'h400000, 24'hC00000);
    drain();
    c.amplitude = 16'hFFFF;
    c.inverse_radius = 24'd65536;
    c.carrier_x = 16'sd0;
    c.carrier_y = 16'sd0;
    apply_settings(c);
    send_point(24'h000080, 24'h000080);
    send_point(24'h7FFFFF, 24'h7FFFFF);
    drain();

    // Random phases; the first runs without idling on either side.
    for (int phase_n = 0; phase_n < RandomPhases; phase_n++) begin
      sender_calm   = (phase_n == 0);
      receiver_calm = (phase_n == 0);
      apply_settings(random_settings());
      for (int i = 0; i < PointsPerPhase; i++) begin
        // Half way through one phase the sender waits for all results.
        if (phase_n == 2 && i == PointsPerPhase / 2) drain();
        if ($urandom_range(0, 3) == 0)
          send_point(24'($urandom_range(0, 4095)) - 24'd2048,
                     24'($urandom_range(0, 4095)) - 24'd2048);
        else
          send_point(24'($urandom), 24'($urandom));
      end
      drain();
    end

    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: gabor_noise_point_evaluator_unit.f
src/gnpe_pkg.sv
src/gnpe_mul.sv
src/gnpe_rom.sv
src/gnpe_core.sv
src/gabor_noise_point_evaluator_unit.sv
tb/gnpe_checker.sv
tb/testbench.sv
